[hw/rtl/sha256_pkg.sv]
// Shared types, constants and the rotate function for the SHA-256 message hasher.
package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       write_byte;   // write byte_data at byte_pos
        logic [5:0] byte_pos;
        logic [7:0] byte_data;
        logic       count_inc;    // bump the message byte count
        logic       count_clear;
        logic       load_work;    // copy chain words into working words
        logic       do_round;
        logic [5:0] round_idx;
        logic       add_chain;    // fold working words into the chain
        logic       chain_init;
    } dp_cmd_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[hw/rtl/sha256_datapath.sv]
// Datapath of the SHA-256 hasher: block buffer, schedule, round logic and chain words.
module sha256_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    output logic [60:0]          byte_count,
    output sha256_pkg::word_t    chain_out [8]
);

    sha256_pkg::word_t sched_reg [16];
    sha256_pkg::word_t work_reg [8];
    sha256_pkg::word_t chain_reg [8];
    logic [60:0]       count_reg;

    sha256_pkg::word_t x15, x2, s0, s1, w_new, w_cur, t1, t2;
    sha256_pkg::word_t a, b, c, d, e, f, g, h;
    logic [3:0] idx_t, idx_15, idx_2, idx_7;
    logic [3:0] byte_word;

    assign idx_t  = cmd.round_idx[3:0];
    assign idx_15 = idx_t + 4'd1;
    assign idx_2  = idx_t + 4'd14;
    assign idx_7  = idx_t + 4'd9;

    always_comb
    begin
        a = work_reg[0]; b = work_reg[1]; c = work_reg[2]; d = work_reg[3];
        e = work_reg[4]; f = work_reg[5]; g = work_reg[6]; h = work_reg[7];
        x15 = sched_reg[idx_15];
        x2  = sched_reg[idx_2];
        s0 = sha256_pkg::rotr(x15, 7) ^ sha256_pkg::rotr(x15, 18) ^ (x15 >> 3);
        s1 = sha256_pkg::rotr(x2, 17) ^ sha256_pkg::rotr(x2, 19) ^ (x2 >> 10);
        w_new = sched_reg[idx_t] + s0 + sched_reg[idx_7] + s1;
        w_cur = (cmd.round_idx[5:4] == 2'd0) ? sched_reg[idx_t] : w_new;
        t1 = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11)
             ^ sha256_pkg::rotr(e, 25)) + ((e & f) ^ (~e & g))
             + sha256_pkg::ROUND_K[cmd.round_idx] + w_cur;
        t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13)
             ^ sha256_pkg::rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    // Block bytes are assembled into schedule words as they arrive, so the
    // buffer is the first sixteen schedule entries.
    assign byte_word = cmd.byte_pos[5:2];

    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
        begin
            unique case (cmd.byte_pos[1:0])
                2'd0: sched_reg[byte_word][31:24] <= cmd.byte_data;
                2'd1: sched_reg[byte_word][23:16] <= cmd.byte_data;
                2'd2: sched_reg[byte_word][15:8]  <= cmd.byte_data;
                default: sched_reg[byte_word][7:0] <= cmd.byte_data;
            endcase
        end
        else if (cmd.do_round)
        begin
            sched_reg[idx_t] <= w_cur;
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (cmd.do_round)
        begin
            work_reg[7] <= g;
            work_reg[6] <= f;
            work_reg[5] <= e;
            work_reg[4] <= d + t1;
            work_reg[3] <= c;
            work_reg[2] <= b;
            work_reg[1] <= a;
            work_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::INIT_H[i];
            count_reg <= '0;
        end
        else
        begin
            if (cmd.chain_init)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sha256_pkg::INIT_H[i];
            end
            else if (cmd.add_chain)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
            if (cmd.count_clear)
                count_reg <= '0;
            else if (cmd.count_inc)
                count_reg <= count_reg + 61'd1;
        end
    end

    assign byte_count = count_reg;
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            chain_out[i] = chain_reg[i];
    end

endmodule

[hw/rtl/sha256_ctrl.sv]
// Controller of the SHA-256 hasher: intake, padding, round sequencing and digest output.
module sha256_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 byte_valid,
    input  logic                 end_of_message,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           word_index,
    output logic                 last_word,
    input  logic [60:0]          byte_count,
    output sha256_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  round_reg, round_next;
    logic [5:0]  pos_reg, pos_next;       // padding write position
    logic        fin_reg, fin_next;       // end pending after this block
    logic        padding_reg, padding_next; // marker still to be written
    logic        len_here_reg, len_here_next; // this block carries the length
    logic [2:0]  widx_reg, widx_next;
    logic [63:0] bits_len;
    logic [63:0] len_shift;
    logic        take;

    assign in_stall = (state_reg != S_IDLE);
    assign take = in_valid && !in_stall;
    assign bits_len = {byte_count, 3'b000};
    // Length bytes go out most significant first from byte 56 on.
    assign len_shift = bits_len >> {~pos_reg[2:0], 3'b000};

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        round_next = round_reg;
        pos_next = pos_reg;
        fin_next = fin_reg;
        padding_next = padding_reg;
        len_here_next = len_here_reg;
        widx_next = widx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (byte_valid)
                    begin
                        cmd.write_byte = 1'b1;
                        cmd.byte_pos = byte_count[5:0];
                        cmd.byte_data = data_byte;
                        cmd.count_inc = 1'b1;
                    end
                    fin_next = end_of_message;
                    pos_next = byte_valid ? byte_count[5:0] + 6'd1 : byte_count[5:0];
                    padding_next = 1'b1;
                    len_here_next = 1'b0;
                    if (byte_valid && byte_count[5:0] == 6'd63)
                        state_next = S_LOAD;
                    else if (end_of_message)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // One byte per cycle: the marker if still pending, zero fill, then the length if this block carries it.
                cmd.write_byte = 1'b1;
                cmd.byte_pos = pos_reg;
                if (padding_reg)
                begin
                    cmd.byte_data = sha256_pkg::PAD_MARKER;
                    padding_next = 1'b0;
                    len_here_next = (pos_reg < sha256_pkg::LEN_POS);
                end
                else if (len_here_reg && pos_reg >= sha256_pkg::LEN_POS)
                    cmd.byte_data = len_shift[7:0];
                else
                    cmd.byte_data = 8'h00;
                pos_next = pos_reg + 6'd1;
                if (pos_reg == 6'd63)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_work = 1'b1;
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                cmd.round_idx = round_reg;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                widx_next = '0;
                pos_next = '0;
                if (!fin_reg)
                    state_next = S_IDLE;
                else if (len_here_reg)
                    state_next = S_OUT;
                else
                begin
                    // Block filled exactly by data, or marker block overflowed:
                    // the next block starts at byte 0 and ends with the length.
                    len_here_next = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        cmd.chain_init = 1'b1;
                        cmd.count_clear = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            round_reg <= '0;
            pos_reg <= '0;
            fin_reg <= 1'b0;
            padding_reg <= 1'b0;
            len_here_reg <= 1'b0;
            widx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            pos_reg <= pos_next;
            fin_reg <= fin_next;
            padding_reg <= padding_next;
            len_here_reg <= len_here_next;
            widx_reg <= widx_next;
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign word_index = widx_reg;
    assign last_word = (widx_reg == 3'd7);

endmodule

[hw/rtl/sha256_message_hasher.sv]
// Top level of the SHA-256 message hasher.
// Usage: message bytes arrive on the input channel, one per transfer, with
// byte_valid set; end_of_message marks the final transfer. A transfer with
// end_of_message and byte_valid low finishes the message without a byte
// (an empty message when nothing came before). A transfer with neither is
// ignored.
// A byte that does not fill a block is taken without a stall. The 64th byte of a
// block starts the compression: a load step, the rounds through the
// single round unit, and a step to fold into the chain words, during
// which in_stall is high. At end of message the padding is written one byte
// per cycle up to the end of the block, then compressed; a second block
// follows when the marker lands at byte 56 or later or the final byte filled a block.
// The digest leaves as eight transfers on the output channel, word_index 0
// first, last_word on the eighth. While out_stall is high the current word
// holds. After the eighth word the chain words and byte count return to
// their initial values. Reset (rst_n low) returns the block to idle with the
// initial chain words and a zero byte count; a digest being sent is dropped.
module sha256_message_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::dp_cmd_t cmd;
    logic [60:0]         byte_count;
    sha256_pkg::word_t   chain_out [8];

    sha256_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .byte_valid(byte_valid),
        .end_of_message(end_of_message),
        .out_valid(out_valid), .out_stall(out_stall),
        .word_index(word_index), .last_word(last_word),
        .byte_count(byte_count), .cmd(cmd)
    );

    sha256_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .byte_count(byte_count), .chain_out(chain_out)
    );

    assign digest_word = chain_out[word_index];

endmodule
